// ----- rtl/ppmfd_pkg.sv -----
// ppmfd_pkg: types, constants and helper functions for the ppm frame decoder
// used by every module of the decoder, depends on nothing
`default_nettype none

package ppmfd_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CAP_W      = 16;
	localparam int PERIOD_W   = 17;
	localparam int SLOT_W     = 7;
	localparam int ANALOG_W   = 7;
	localparam int SW_W       = 2;
	localparam int IDLE_W     = 7;
	localparam int CHAN_W     = 3;
	localparam int NUM_SLOTS  = 6;
	localparam int NUM_ANALOG = 4;
	localparam int DATA_W     = 40;

	localparam logic [CAP_W-1:0] TIMER_MASK = (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}} :
		CAP_W'((64'd1 << TIMER_BITS) - 64'd1);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(65536);

	// round to tenths: (x + 5) * ceil(2^21 / 10) >> 21, exact for x below 2^17
	localparam int XR_W        = 18;
	localparam int QUOT_W      = 15;
	localparam int RECIP_SHIFT = 21;
	localparam logic [XR_W-1:0]   RECIP_10   = XR_W'(209716);
	localparam logic [XR_W-1:0]   ROUND_HALF = XR_W'(5);

	localparam logic [QUOT_W-1:0] SYNC_LIMIT  = QUOT_W'(500);
	localparam logic [QUOT_W-1:0] SLOT_OFFSET = QUOT_W'(100);
	localparam logic [QUOT_W-1:0] SLOT_TOP    = QUOT_W'(200);
	localparam logic [SLOT_W-1:0] SLOT_MAX    = SLOT_W'(100);
	localparam logic [SLOT_W-1:0] CENTRE      = SLOT_W'(50);
	localparam logic [SLOT_W-1:0] SW_UP_BELOW   = SLOT_W'(25);
	localparam logic [SLOT_W-1:0] SW_DOWN_ABOVE = SLOT_W'(75);
	localparam logic [IDLE_W-1:0] IDLE_LIMIT  = IDLE_W'(100);
	localparam logic [CHAN_W-1:0] CHAN_WAIT   = CHAN_W'(0);
	localparam logic [CHAN_W-1:0] CHAN_FIRST  = CHAN_W'(1);
	localparam logic [CHAN_W-1:0] CHAN_LAST   = CHAN_W'(NUM_SLOTS);

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [SW_W-1:0] {
		SW_NONE = 2'd0,
		SW_UP   = 2'd1,
		SW_DOWN = 2'd2
	} switch_t;

	typedef struct packed {
		logic             kind;
		logic [CAP_W-1:0] capture_value;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	typedef struct packed {
		logic                       frame_synced;
		logic                       link_alive;
		switch_t                    right_switch;
		switch_t                    left_switch;
		logic signed [ANALOG_W-1:0] analog_3;
		logic signed [ANALOG_W-1:0] analog_2;
		logic signed [ANALOG_W-1:0] analog_1;
		logic signed [ANALOG_W-1:0] analog_0;
		logic                       frame_done;
	} result_t;

	function automatic switch_t to_switch(input logic [SLOT_W-1:0] v);
		switch_t s;
		if (v < SW_UP_BELOW)
			s = SW_UP;
		else if (v > SW_DOWN_ABOVE)
			s = SW_DOWN;
		else
			s = SW_NONE;
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ppmfd_in_stage.sv -----
// ppmfd_in_stage: input register of the decoder, takes one request a cycle while the decode stage advances
// depends on ppmfd_pkg
`default_nettype none

module ppmfd_in_stage
	import ppmfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire item_t  in_item,
	input  wire logic   advance,
	output stage_t      stage
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

`default_nettype wire

// ----- rtl/ppmfd_decode.sv -----
// ppmfd_decode: edge timing, channel sequencing, latched outputs and result register
// depends on ppmfd_pkg
`default_nettype none

module ppmfd_decode
	import ppmfd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [PERIOD_W-1:0] cfg_wdata,
	input  wire stage_t              stage,
	output logic                     advance,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output result_t                  result
);

	logic [PERIOD_W-1:0] period_q;
	logic [CAP_W-1:0]    last_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [IDLE_W-1:0]   idle_q;
	logic                synced_q;
	logic [SLOT_W-1:0]   slot_q [NUM_SLOTS];
	logic signed [ANALOG_W-1:0] analog_q [NUM_ANALOG];
	switch_t             left_q;
	switch_t             right_q;
	logic                out_valid_q;
	result_t             res_q;

	logic                fire;
	logic [CAP_W-1:0]    cur;
	logic [CAP_W+1:0]    diff;
	logic [CAP_W-1:0]    mag;
	logic [CAP_W+1:0]    wrapped;
	logic                neg_final;
	logic [XR_W-2:0]     x;
	logic [XR_W-1:0]     xr;
	logic [2*XR_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic                is_sync;
	logic [SLOT_W-1:0]   slot_val;
	logic [CHAN_W-1:0]   slot_idx;
	logic                slot_we;
	logic                latch;

	logic [CHAN_W-1:0]   chan_d;
	logic [IDLE_W-1:0]   idle_d;
	logic                synced_d;
	result_t             res_d;

	assign advance = !out_valid_q || out_ready;
	assign fire    = stage.valid && advance;

	// edge difference, wrapped by the timer period when it goes negative
	always_comb begin
		cur       = stage.item.capture_value & TIMER_MASK;
		diff      = {2'b00, cur} - {2'b00, last_q};
		mag       = last_q - cur;
		wrapped   = {1'b0, period_q} - {2'b00, mag};
		neg_final = diff[CAP_W+1] && wrapped[CAP_W+1];
		x         = diff[CAP_W+1] ? wrapped[XR_W-2:0] : {1'b0, diff[CAP_W-1:0]};
		xr        = {1'b0, x} + ROUND_HALF;
		prod      = {{XR_W{1'b0}}, xr} * {{XR_W{1'b0}}, RECIP_10};
		quot      = prod[RECIP_SHIFT +: QUOT_W];
		is_sync   = !neg_final && (quot > SYNC_LIMIT);
		if (neg_final || quot < SLOT_OFFSET)
			slot_val = '0;
		else if (quot > SLOT_TOP)
			slot_val = SLOT_MAX;
		else
			slot_val = SLOT_W'(quot - SLOT_OFFSET);
	end

	// channel sequencing and next state
	always_comb begin
		chan_d   = chan_q;
		idle_d   = idle_q;
		synced_d = synced_q;
		slot_we  = 1'b0;
		latch    = 1'b0;
		slot_idx = chan_q - CHAN_FIRST;
		if (stage.item.kind == KIND_TICK) begin
			if (idle_q < IDLE_LIMIT)
				idle_d = idle_q + IDLE_W'(1);
		end else begin
			idle_d = '0;
			if (is_sync) begin
				if (chan_q != CHAN_WAIT)
					synced_d = 1'b0;
				chan_d = CHAN_FIRST;
			end else if (chan_q == CHAN_WAIT) begin
				synced_d = 1'b0;
			end else begin
				slot_we = 1'b1;
				if (chan_q >= CHAN_LAST) begin
					synced_d = 1'b1;
					chan_d   = CHAN_WAIT;
					latch    = 1'b1;
				end else begin
					chan_d = chan_q + CHAN_W'(1);
				end
			end
		end
	end

	// result from the state after this request
	always_comb begin
		res_d.frame_done   = latch;
		res_d.link_alive   = idle_d < IDLE_LIMIT;
		res_d.frame_synced = synced_d;
		if (latch) begin
			res_d.analog_0     = ANALOG_W'(slot_q[0] - CENTRE);
			res_d.analog_1     = ANALOG_W'(slot_q[1] - CENTRE);
			res_d.analog_2     = ANALOG_W'(slot_q[2] - CENTRE);
			res_d.analog_3     = ANALOG_W'(slot_q[3] - CENTRE);
			res_d.left_switch  = to_switch(slot_q[4]);
			res_d.right_switch = to_switch(slot_val);
		end else begin
			res_d.analog_0     = analog_q[0];
			res_d.analog_1     = analog_q[1];
			res_d.analog_2     = analog_q[2];
			res_d.analog_3     = analog_q[3];
			res_d.left_switch  = left_q;
			res_d.right_switch = right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			last_q      <= '0;
			chan_q      <= CHAN_WAIT;
			idle_q      <= '0;
			synced_q    <= 1'b0;
			analog_q    <= '{default: '0};
			left_q      <= SW_NONE;
			right_q     <= SW_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				period_q <= cfg_wdata;
			if (advance)
				out_valid_q <= stage.valid;
			if (fire) begin
				chan_q   <= chan_d;
				idle_q   <= idle_d;
				synced_q <= synced_d;
				if (stage.item.kind == KIND_EDGE)
					last_q <= cur;
				analog_q[0] <= res_d.analog_0;
				analog_q[1] <= res_d.analog_1;
				analog_q[2] <= res_d.analog_2;
				analog_q[3] <= res_d.analog_3;
				left_q      <= res_d.left_switch;
				right_q     <= res_d.right_switch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && slot_we)
			slot_q[slot_idx] <= slot_val;
		if (fire)
			res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

`default_nettype wire

// ----- rtl/ppm_frame_decoder_top.sv -----
// ppm_frame_decoder_top: six-channel pulse-position stream decoder
// path: input register, then result register on the master side
// throughput: one request per cycle unless m_tready holds the output, set by the
// single decode pass between the input register and the result register
// reset: arst_n clears all control state, the timer period returns to 65536
// depends on ppmfd_pkg, ppmfd_in_stage and ppmfd_decode
`default_nettype none

module ppm_frame_decoder_top
	import ppmfd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [PERIOD_W-1:0] cfg_wdata,   // timer_period
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [CAP_W-1:0]    s_tdata,     // capture_value
	input  wire logic                s_tuser,     // kind
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic                     m_tlast,     // frame_done
	// analog_0, analog_1, analog_2, analog_3, left_switch, right_switch,
	// link_alive, frame_synced, zero fill
	output logic [DATA_W-1:0]        m_tdata
);

	item_t   in_item;
	stage_t  stage;
	logic    advance;
	result_t result;

	assign in_item.kind          = s_tuser;
	assign in_item.capture_value = s_tdata;

	ppmfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.stage    (stage)
	);

	ppmfd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stage     (stage),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tlast = result.frame_done;
	assign m_tdata = {6'd0, result.frame_synced, result.link_alive, result.right_switch,
		result.left_switch, result.analog_3, result.analog_2, result.analog_1,
		result.analog_0};

endmodule

`default_nettype wire
